### rtl/core/mnls_pkg.sv
// Shared types and constants of the Markov note learner and sampler.
// No dependencies; every module of the block imports this package.
package mnls_pkg;

  // default sizes of the block
  localparam int unsigned MNLS_MAX_NOTES  = 16;
  localparam int unsigned MNLS_COUNT_BITS = 32;

  // configuration register indexes
  localparam logic [1:0] CFG_RECORD_MODE = 2'd0;
  localparam logic [1:0] CFG_NOTE_OFFSET = 2'd1;
  localparam logic [1:0] CFG_DIM_IN_USE  = 2'd2;

  // reset value of the dimension register
  localparam logic [4:0] DIM_RESET = 5'd12;

  // input item kinds
  typedef enum logic [1:0] {
    KIND_NOTE    = 2'd0,
    KIND_BANG    = 2'd1,
    KIND_SETPREV = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // latch the accepted item
    logic clr_init;  // start a table clear
    logic clr_step;  // zero one table entry
    logic rec_rd;    // read row total and count for a record
    logic rec_wr;    // write back incremented total and count
    logic tot_rd;    // read the row total for a pick
    logic mul;       // form the pick target, read first column
    logic scan;      // accumulate one column
    logic push;      // load the output register
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic rec_mode;   // record mode register
    logic seen;       // a note has been seen
    logic clr_last;   // last entry of the clear sweep
    logic scan_done;  // pick found in this column, or last column reached
    logic slot_free;  // output register can take an item
  } sts_t;

endpackage

### rtl/core/markov_note_learner_sampler.sv
// Top level of the Markov note learner and sampler: stream ports, controller
// and datapath. Depends on mnls_pkg, mnls_ctrl and mnls_dp.
//
//  channel   direction  handshake                       payload
//  s_axis    in         s_axis_tvalid / s_axis_tready   tdata note_in, rand_start, rand_pick; tuser kind
//  m_axis    out        m_axis_tvalid / m_axis_tready   tdata note_out
//  cfg       in         cfg_we_i (no wait)              cfg_idx_i, cfg_wdata_i
//
// A play note or bang runs a pick: it reads the row total, forms the target and scans the row
// one column a cycle, stopping at the chosen column. The row is the played note's index, the
// previous note for a bang, or a random start row before any note is seen. A record note reads
// and writes back its count and row total (only latched before any note is seen). A clear
// pass zeroes every table entry; reset runs the same pass, and s_axis_tready stays low meanwhile.
// A finished item waits in the output register while the next item is taken.
module markov_note_learner_sampler #(
  parameter int unsigned MAX_NOTES  = mnls_pkg::MNLS_MAX_NOTES,
  parameter int unsigned COUNT_BITS = mnls_pkg::MNLS_COUNT_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // note_in [7:0], rand_start [23:8], rand_pick [39:24]
  input  logic [1:0]  s_axis_tuser,  // kind [1:0]
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // note_out [8:0], zero [15:9]
);
  import mnls_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  kind_e      kind;
  logic [8:0] note_out;

  assign kind = kind_e'(s_axis_tuser);

  // sequencing
  mnls_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .kind_i  (kind),
    .sts_i   (sts),
    .ready_o (s_axis_tready),
    .cmd_o   (cmd)
  );

  // storage and arithmetic
  mnls_dp #(
    .MAX_NOTES  (MAX_NOTES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .kind_i      (kind),
    .note_i      (s_axis_tdata[7:0]),
    .rstart_i    (s_axis_tdata[23:8]),
    .rpick_i     (s_axis_tdata[39:24]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .note_out_o  (note_out)
  );

  assign m_axis_tdata = {7'd0, note_out};

  // a result never overwrites one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register overwritten");

  // no item is taken during a clear pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_step |-> !s_axis_tready)
    else $error("item accepted during clear");

  // items are latched only on an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (s_axis_tvalid && s_axis_tready))
    else $error("load without accept");

  // the pick target is formed right after the row total read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.tot_rd |=> cmd.mul)
    else $error("pick sequence broken");

endmodule

### rtl/core/mnls_ctrl.sv
// Controller of the Markov note learner and sampler: sequences clear,
// record and pick work. Depends on mnls_pkg.
module mnls_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  mnls_pkg::kind_e      kind_i,
  input  mnls_pkg::sts_t       sts_i,
  output logic                 ready_o,
  output mnls_pkg::cmd_t       cmd_o
);
  import mnls_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_REC_RD,
    ST_REC_WR,
    ST_TOT_RD,
    ST_MUL,
    ST_SCAN,
    ST_PUSH
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (valid_i) begin
          case (kind_i)
            KIND_CLEAR: begin
              cmd_o.clr_init = 1'b1;
              state_d        = ST_CLEAR;
            end
            KIND_SETPREV: begin
              cmd_o.load = 1'b1;
            end
            KIND_NOTE: begin
              cmd_o.load = 1'b1;
              if (!sts_i.rec_mode) begin
                state_d = ST_TOT_RD;
              end else if (sts_i.seen) begin
                state_d = ST_REC_RD;
              end
            end
            KIND_BANG: begin
              if (!sts_i.rec_mode) begin
                cmd_o.load = 1'b1;
                state_d    = ST_TOT_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_REC_RD: begin
        cmd_o.rec_rd = 1'b1;
        state_d      = ST_REC_WR;
      end
      ST_REC_WR: begin
        cmd_o.rec_wr = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_TOT_RD: begin
        cmd_o.tot_rd = 1'b1;
        state_d      = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (sts_i.slot_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and ready; reset runs a table clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == ST_IDLE);
    end
  end

  assign ready_o = ready_q;

endmodule

### rtl/core/mnls_dp.sv
// Datapath of the Markov note learner and sampler: configuration, count
// and row total memories, pick arithmetic, output register. Depends on mnls_pkg.
module mnls_dp #(
  parameter int unsigned MAX_NOTES  = mnls_pkg::MNLS_MAX_NOTES,
  parameter int unsigned COUNT_BITS = mnls_pkg::MNLS_COUNT_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [7:0]           cfg_wdata_i,
  input  mnls_pkg::kind_e      kind_i,
  input  logic [7:0]           note_i,
  input  logic [15:0]          rstart_i,
  input  logic [15:0]          rpick_i,
  input  mnls_pkg::cmd_t       cmd_i,
  output mnls_pkg::sts_t       sts_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [8:0]           note_out_o
);
  import mnls_pkg::*;

  localparam int unsigned RW     = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int unsigned DW     = $clog2(MAX_NOTES + 1);
  localparam int unsigned EW     = (DW > 5) ? DW : 5;
  localparam int unsigned AW     = 2 * RW;
  localparam int unsigned CDEPTH = 1 << AW;
  localparam int unsigned RDEPTH = 1 << RW;
  localparam int unsigned TW     = COUNT_BITS + 16;

  // configuration registers
  logic       rec_mode_q;
  logic [7:0] offset_q;
  logic [4:0] dim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_mode_q <= 1'b0;
      offset_q   <= 8'd0;
      dim_q      <= DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RECORD_MODE: rec_mode_q <= cfg_wdata_i[0];
        CFG_NOTE_OFFSET: offset_q   <= cfg_wdata_i;
        CFG_DIM_IN_USE:  dim_q      <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  // effective dimension, saturated into one to MAX_NOTES
  logic [EW-1:0] dim_ext;
  logic [EW-1:0] dim_sat;
  logic [DW-1:0] eff_dim;
  logic [RW-1:0] dim_m1;

  assign dim_ext = EW'(dim_q);
  assign dim_sat = (dim_q == 5'd0) ? EW'(1) :
                   (dim_ext > EW'(MAX_NOTES)) ? EW'(MAX_NOTES) : dim_ext;
  assign eff_dim = DW'(dim_sat);
  assign dim_m1  = RW'(eff_dim - DW'(1));

  // control state of the model
  logic [RW-1:0] prev_q;
  logic          seen_q;

  // item registers
  logic [RW-1:0] row_q;
  logic [RW-1:0] idx_q;
  logic [15:0]   rpick_q;

  // note to index
  logic [7:0]    note_diff;
  logic [RW-1:0] note_idx;

  assign note_diff = note_i - offset_q;
  assign note_idx  = (note_i < offset_q) ? '0 :
                     (note_diff >= 8'(eff_dim)) ? dim_m1 : note_diff[RW-1:0];

  // row of the item: random start row, or clamped played note or previous index
  logic [RW-1:0]    base_idx;
  logic [RW-1:0]    base_clamp;
  logic [16+DW-1:0] start_prod;
  logic [RW-1:0]    start_row;
  logic [RW-1:0]    row_d;

  assign base_idx   = (!rec_mode_q && kind_i == KIND_NOTE) ? note_idx : prev_q;
  assign base_clamp = (DW'(base_idx) >= eff_dim) ? dim_m1 : base_idx;
  assign start_prod = (16+DW)'(rstart_i) * (16+DW)'(eff_dim);
  assign start_row  = start_prod[16 +: RW];
  assign row_d      = (!rec_mode_q && !seen_q) ? start_row : base_clamp;

  // pick scan registers
  logic [RW-1:0]         col_q;
  logic [COUNT_BITS-1:0] cum_q;
  logic [TW-1:0]         target_q;
  logic [COUNT_BITS-1:0] cnt_rd_q;
  logic [COUNT_BITS-1:0] tot_q;
  logic [COUNT_BITS-1:0] cum_new;
  logic                  hit;
  logic                  scan_done;

  assign cum_new   = cum_q + cnt_rd_q;
  assign hit       = {cum_new, 16'h0000} >= target_q;
  assign scan_done = cmd_i.scan && (hit || col_q == dim_m1);

  // clear sweep counter
  logic [AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_init) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  // previous index and seen flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      seen_q <= 1'b0;
    end else if (cmd_i.clr_init) begin
      prev_q <= '0;
      seen_q <= 1'b0;
    end else if (cmd_i.load) begin
      if (kind_i == KIND_NOTE || kind_i == KIND_SETPREV) begin
        prev_q <= note_idx;
      end
      if (rec_mode_q && kind_i == KIND_NOTE) begin
        seen_q <= 1'b1;
      end
    end else if (scan_done) begin
      prev_q <= col_q;
      seen_q <= 1'b1;
    end
  end

  // item payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      row_q   <= row_d;
      idx_q   <= note_idx;
      rpick_q <= rpick_i;
    end
  end

  // scan arithmetic
  logic [TW-1:0] target_d;

  assign target_d = TW'(rpick_q) * TW'(tot_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      target_q <= target_d;
      cum_q    <= '0;
      col_q    <= '0;
    end else if (cmd_i.scan) begin
      cum_q <= cum_new;
      col_q <= col_q + RW'(1);
    end
  end

  // transition count memory
  logic [COUNT_BITS-1:0] cnt_mem [CDEPTH];
  logic [AW-1:0]         cnt_raddr;
  logic                  cnt_ren;
  logic                  sat;

  assign sat       = (tot_q == '1);
  assign cnt_ren   = cmd_i.rec_rd || cmd_i.mul || cmd_i.scan;
  assign cnt_raddr = cmd_i.rec_rd ? {row_q, idx_q} :
                     cmd_i.mul    ? {row_q, RW'(0)} :
                                    {row_q, RW'(col_q + RW'(1))};

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      cnt_mem[clr_cnt_q] <= '0;
    end else if (cmd_i.rec_wr && !sat) begin
      cnt_mem[{row_q, idx_q}] <= cnt_rd_q + COUNT_BITS'(1);
    end
    if (cnt_ren) begin
      cnt_rd_q <= cnt_mem[cnt_raddr];
    end
  end

  // row total memory
  logic [COUNT_BITS-1:0] tot_mem [RDEPTH];

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      tot_mem[clr_cnt_q[RW-1:0]] <= '0;
    end else if (cmd_i.rec_wr && !sat) begin
      tot_mem[row_q] <= tot_q + COUNT_BITS'(1);
    end
    if (cmd_i.rec_rd || cmd_i.tot_rd) begin
      tot_q <= tot_mem[row_q];
    end
  end

  // output register
  logic       out_valid_q;
  logic [8:0] note_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      note_out_q <= {1'b0, offset_q} + 9'(prev_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign note_out_o  = note_out_q;

  // status
  assign sts_o.rec_mode  = rec_mode_q;
  assign sts_o.seen      = seen_q;
  assign sts_o.clr_last  = (clr_cnt_q == '1);
  assign sts_o.scan_done = scan_done;
  assign sts_o.slot_free = !out_valid_q || out_ready_i;

endmodule
